>>> hw/rtl/qsd_pkg.sv
// Package for the quadrature stroke detector: opcodes, phases, register map,
// ring sizes and the quadrature step table. No dependencies.
package qsd_pkg;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_PINS = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PH_TOP    = 2'd0,
        PH_DOWN   = 2'd1,
        PH_RETURN = 2'd2
    } t_phase;

    localparam logic [2:0] REG_TOP_LEAVE  = 3'd0;
    localparam logic [2:0] REG_TOP_ENTER  = 3'd1;
    localparam logic [2:0] REG_BOTTOM     = 3'd2;
    localparam logic [2:0] REG_MICRO      = 3'd3;
    localparam logic [2:0] REG_SHORT      = 3'd4;
    localparam logic [2:0] REG_GAP        = 3'd5;
    localparam logic [2:0] REG_IDLE       = 3'd6;
    localparam logic [2:0] REG_TIMEOUT    = 3'd7;

    // Stroke-time ring size (a power of two) and the number of intervals summed.
    localparam int RING_DEPTH  = 8;
    localparam int RATE_WINDOW = 5;

    // Position step for (previous pins, new pins), each as {a, b}.
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] d;
        begin
            case (idx)
                4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
                4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
                default: d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

>>> hw/rtl/quadrature_stroke_detector_unit.sv
// Quadrature stroke detector: pin decoding, session timing, stroke machine
// and stroke-time ring with a registered interval summary.
// Depends on qsd_pkg.

// Each result beat is registered and is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the sink takes results; all state updates in a single pass of
// compare and add logic between the input stage and the result register.
// Interval sum and count are rebuilt from the ring each beat (window adders).
// Reset (synchronous, active low) clears all state and the config registers; result data is not reset.
module quadrature_stroke_detector_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream. tdata: [0] pin_a, [1] pin_b, [33:2] now_ms, rest zero.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    // tuser: [1:0] opcode.
    input  logic [1:0]   s_axis_tuser,
    // Result stream. tdata from bit 0: position 32, phase 2, session_on 1,
    // active_ms 32, valid_strokes 32, short_strokes 32, micro_strokes 32,
    // valid_travel_sum 48, short_travel_sum 48, micro_travel_sum 48,
    // interval_sum_ms 35, interval_count 3, then zero fill.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [351:0] m_axis_tdata,
    // Register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RW = $clog2(qsd_pkg::RING_DEPTH);
    localparam int CW = $clog2(qsd_pkg::RATE_WINDOW + 1);
    localparam int SW = 32 + $clog2(qsd_pkg::RATE_WINDOW + 1);

    // Configuration registers.
    logic signed [31:0] r_top_leave, r_top_enter, r_bottom;
    logic [30:0] r_micro, r_short;
    logic [31:0] r_gap, r_idle, r_timeout;
    logic [2:0]  w_cfg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_leave <= '0; r_top_enter <= '0; r_bottom <= '0;
            r_micro <= '0; r_short <= '0;
            r_gap <= '0; r_idle <= '0; r_timeout <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                qsd_pkg::REG_TOP_LEAVE: r_top_leave <= pwdata;
                qsd_pkg::REG_TOP_ENTER: r_top_enter <= pwdata;
                qsd_pkg::REG_BOTTOM:    r_bottom    <= pwdata;
                qsd_pkg::REG_MICRO:     r_micro     <= pwdata[30:0];
                qsd_pkg::REG_SHORT:     r_short     <= pwdata[30:0];
                qsd_pkg::REG_GAP:       r_gap       <= pwdata;
                qsd_pkg::REG_IDLE:      r_idle      <= pwdata;
                qsd_pkg::REG_TIMEOUT:   r_timeout   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            qsd_pkg::REG_TOP_LEAVE: prdata = r_top_leave;
            qsd_pkg::REG_TOP_ENTER: prdata = r_top_enter;
            qsd_pkg::REG_BOTTOM:    prdata = r_bottom;
            qsd_pkg::REG_MICRO:     prdata = {1'b0, r_micro};
            qsd_pkg::REG_SHORT:     prdata = {1'b0, r_short};
            qsd_pkg::REG_GAP:       prdata = r_gap;
            qsd_pkg::REG_IDLE:      prdata = r_idle;
            qsd_pkg::REG_TIMEOUT:   prdata = r_timeout;
            default:                prdata = '0;
        endcase
    end

    // Handshake: the result register frees as soon as the sink takes it.
    logic w_in_fire, w_out_fire;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;

    // Block state.
    logic [1:0]          r_prev_pins, n_prev_pins;
    logic signed [31:0]  r_pos, n_pos;
    logic                r_moved, n_moved, r_sess, n_sess;
    logic [31:0]         r_last_move, n_last_move, r_last_acc, n_last_acc;
    logic [31:0]         r_active, n_active;
    qsd_pkg::t_phase     r_phase, n_phase;
    logic signed [31:0]  r_low, n_low, r_high, n_high;
    logic [31:0]         r_last_stroke, n_last_stroke;
    logic [31:0]         r_cnt_v, n_cnt_v, r_cnt_s, n_cnt_s, r_cnt_m, n_cnt_m;
    logic [47:0]         r_sum_v, n_sum_v, r_sum_s, n_sum_s, r_sum_m, n_sum_m;
    logic [31:0]         r_ring [qsd_pkg::RING_DEPTH];
    logic [RW-1:0]       r_slot, n_slot;
    logic                n_ring_wr;

    logic [1:0]          w_op;
    logic [1:0]          w_pins;
    logic [31:0]         w_now;
    logic signed [1:0]   w_step;
    logic [31:0]         w_since_move, w_travel;
    logic signed [31:0]  w_low2, w_high2;

    assign w_op   = s_axis_tuser;
    assign w_pins = {s_axis_tdata[0], s_axis_tdata[1]};
    assign w_now  = s_axis_tdata[33:2];
    assign w_step = qsd_pkg::quad_step({r_prev_pins, w_pins});

    // Next-state logic for one beat.
    always_comb begin
        n_prev_pins = r_prev_pins; n_pos = r_pos; n_moved = r_moved;
        n_sess = r_sess; n_last_move = r_last_move; n_last_acc = r_last_acc;
        n_active = r_active; n_phase = r_phase; n_low = r_low; n_high = r_high;
        n_last_stroke = r_last_stroke;
        n_cnt_v = r_cnt_v; n_cnt_s = r_cnt_s; n_cnt_m = r_cnt_m;
        n_sum_v = r_sum_v; n_sum_s = r_sum_s; n_sum_m = r_sum_m;
        n_slot = r_slot; n_ring_wr = 1'b0;
        w_since_move = '0;
        w_low2  = (r_pos < r_low)  ? r_pos : r_low;
        w_high2 = (r_pos > r_high) ? r_pos : r_high;
        w_travel = w_high2 - w_low2;
        case (qsd_pkg::t_opcode'(w_op))
            qsd_pkg::OP_INIT: n_prev_pins = w_pins;
            qsd_pkg::OP_PINS: begin
                if (w_step != 2'sd0) begin
                    n_pos   = r_pos + {{30{w_step[1]}}, w_step};
                    n_moved = 1'b1;
                end
                n_prev_pins = w_pins;
            end
            qsd_pkg::OP_TICK: begin
                // Session and active time.
                if (r_moved) begin
                    n_last_move = w_now;
                    if (!r_sess) begin
                        n_sess = 1'b1;
                        n_last_acc = w_now;
                    end
                end
                n_moved = 1'b0;
                w_since_move = w_now - n_last_move;
                if (n_sess) begin
                    if (w_since_move <= r_idle && n_last_acc != '0)
                        n_active = r_active + (w_now - n_last_acc);
                    n_last_acc = w_now;
                    if (w_since_move > r_timeout)
                        n_sess = 1'b0;
                end
                // Stroke machine.
                case (r_phase)
                    qsd_pkg::PH_DOWN: begin
                        n_low = w_low2; n_high = w_high2;
                        if (w_low2 <= r_bottom)
                            n_phase = qsd_pkg::PH_RETURN;
                        else if (r_pos >= r_top_enter) begin
                            if (w_travel <= {1'b0, r_micro}) begin
                                n_cnt_m = r_cnt_m + 32'd1;
                                n_sum_m = r_sum_m + {16'd0, w_travel};
                            end else if (w_travel <= {1'b0, r_short}) begin
                                n_cnt_s = r_cnt_s + 32'd1;
                                n_sum_s = r_sum_s + {16'd0, w_travel};
                            end
                            n_phase = qsd_pkg::PH_TOP;
                        end
                    end
                    qsd_pkg::PH_RETURN: begin
                        n_low = w_low2; n_high = w_high2;
                        if (r_pos >= r_top_enter) begin
                            if (w_now - r_last_stroke >= r_gap) begin
                                n_cnt_v = r_cnt_v + 32'd1;
                                n_last_stroke = w_now;
                                n_sum_v = r_sum_v + {16'd0, w_travel};
                                n_ring_wr = 1'b1;
                                n_slot = (r_slot == RW'(qsd_pkg::RING_DEPTH - 1)) ? '0
                                         : r_slot + RW'(1);
                            end
                            n_phase = qsd_pkg::PH_TOP;
                        end
                    end
                    default: begin
                        n_low = r_pos; n_high = r_pos;
                        n_phase = (r_pos <= r_top_leave) ? qsd_pkg::PH_DOWN
                                                         : qsd_pkg::PH_TOP;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= '0; r_pos <= '0; r_moved <= 1'b0; r_sess <= 1'b0;
            r_last_move <= '0; r_last_acc <= '0; r_active <= '0;
            r_phase <= qsd_pkg::PH_TOP; r_low <= '0; r_high <= '0;
            r_last_stroke <= '0;
            r_cnt_v <= '0; r_cnt_s <= '0; r_cnt_m <= '0;
            r_sum_v <= '0; r_sum_s <= '0; r_sum_m <= '0;
            r_slot <= '0;
            for (int i = 0; i < qsd_pkg::RING_DEPTH; i++) r_ring[i] <= '0;
        end else if (w_in_fire) begin
            r_prev_pins <= n_prev_pins; r_pos <= n_pos; r_moved <= n_moved;
            r_sess <= n_sess; r_last_move <= n_last_move; r_last_acc <= n_last_acc;
            r_active <= n_active; r_phase <= n_phase; r_low <= n_low;
            r_high <= n_high; r_last_stroke <= n_last_stroke;
            r_cnt_v <= n_cnt_v; r_cnt_s <= n_cnt_s; r_cnt_m <= n_cnt_m;
            r_sum_v <= n_sum_v; r_sum_s <= n_sum_s; r_sum_m <= n_sum_m;
            r_slot <= n_slot;
            if (n_ring_wr) r_ring[r_slot] <= w_now;
        end
    end

    // Interval summary over the newest ring pairs, computed from next state.
    // The ring depth is a power of two, so slot indexes wrap on their own.
    logic [31:0]   w_ring_next [qsd_pkg::RING_DEPTH];
    logic [SW-1:0] w_isum;
    logic [CW-1:0] w_icnt;

    always_comb begin
        logic [31:0] t1, t2;
        logic [RW-1:0] k1, k2;
        for (int i = 0; i < qsd_pkg::RING_DEPTH; i++)
            w_ring_next[i] = (n_ring_wr && r_slot == RW'(i)) ? w_now : r_ring[i];
        w_isum = '0;
        w_icnt = '0;
        for (int i = 0; i < qsd_pkg::RATE_WINDOW; i++) begin
            k1 = n_slot - RW'(i + 1);
            k2 = n_slot - RW'(i + 2);
            t1 = w_ring_next[k1];
            t2 = w_ring_next[k2];
            if (t1 != '0 && t2 != '0 && t1 > t2) begin
                w_isum = w_isum + SW'(t1 - t2);
                w_icnt = w_icnt + CW'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_in_fire) begin
            m_axis_tvalid <= 1'b1;
        end else if (w_out_fire) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            m_axis_tdata <= {7'd0, 3'(w_icnt), 35'(w_isum), n_sum_m, n_sum_s,
                             n_sum_v, n_cnt_m, n_cnt_s, n_cnt_v, n_active,
                             n_sess, n_phase, n_pos};
        end
    end

`ifndef SYNTH
    // A result beat waiting for the sink must not be overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result overwritten while stalled");
    // The phase field never carries the unused code.
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
        else $error("bad phase code");
    // The ring slot advances only on a tick beat.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_fire && s_axis_tuser == qsd_pkg::OP_TICK) |=> $stable(r_slot))
        else $error("ring slot moved without a tick");
`endif

endmodule

>>> tb/quadrature_stroke_detector_unit_tb.sv
// Testbench for quadrature_stroke_detector_unit: drives pin, init and tick beats
// through the input stream, writes the threshold registers over APB and checks
// every result beat against a bit-accurate predictor. Depends on qsd_pkg.
`timescale 1ns / 100ps

module quadrature_stroke_detector_unit_tb;

    // Field widths of a result beat, lowest bits first.
    localparam int NFIELD = 12;
    localparam int FIELD_W [NFIELD] = '{32, 2, 1, 32, 32, 32, 32, 48, 48, 48, 35, 3};

    // Scoreboard: shadow state of the detector and the queue of pending results.
    class stroke_scoreboard;
        bit [351:0] pending_results[$];
        int mismatches;
        longint top_leave, top_enter, bottom_lvl, micro_lim, short_lim;
        bit [31:0] gap_ms, idle_ms, timeout_ms;
        bit [1:0] prev_pins;
        bit [31:0] enc_pos;
        bit moved, in_sess;
        bit [31:0] last_move, last_accrue, active;
        qsd_pkg::t_phase phase;
        longint cyc_low, cyc_high;
        bit [31:0] last_stroke, n_valid, n_short, n_micro;
        bit [47:0] s_valid, s_short, s_micro;
        bit [31:0] ring [qsd_pkg::RING_DEPTH];
        bit [2:0] slot;
        int step_tab [16];

        function new();
            step_tab = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
            top_leave = 0; top_enter = 0; bottom_lvl = 0; micro_lim = 0; short_lim = 0;
            gap_ms = 0; idle_ms = 0; timeout_ms = 0;
            prev_pins = 0; enc_pos = 0; moved = 0; in_sess = 0;
            last_move = 0; last_accrue = 0; active = 0; phase = qsd_pkg::PH_TOP;
            cyc_low = 0; cyc_high = 0; last_stroke = 0;
            n_valid = 0; n_short = 0; n_micro = 0;
            s_valid = 0; s_short = 0; s_micro = 0;
            foreach (ring[i]) ring[i] = 0;
            slot = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [31:0] val);
            case (idx)
                qsd_pkg::REG_TOP_LEAVE: top_leave = longint'($signed(val));
                qsd_pkg::REG_TOP_ENTER: top_enter = longint'($signed(val));
                qsd_pkg::REG_BOTTOM:    bottom_lvl = longint'($signed(val));
                qsd_pkg::REG_MICRO:     micro_lim = longint'(val[30:0]);
                qsd_pkg::REG_SHORT:     short_lim = longint'(val[30:0]);
                qsd_pkg::REG_GAP:       gap_ms = val;
                qsd_pkg::REG_IDLE:      idle_ms = val;
                default:                timeout_ms = val;
            endcase
        endfunction

        function longint position();
            return longint'($signed(enc_pos));
        endfunction

        // Session timing, cycle extremes and the stroke machine for one tick.
        function void tick(bit [31:0] now);
            longint pos;
            longint travel;
            pos = position();
            if (moved) begin
                last_move = now;
                if (!in_sess) begin
                    in_sess = 1;
                    last_accrue = now;
                end
            end
            moved = 0;
            if (in_sess) begin
                if (bit'(now - last_move <= idle_ms) && last_accrue != 0)
                    active = active + (now - last_accrue);
                last_accrue = now;
            end
            if (in_sess && (now - last_move) > timeout_ms) in_sess = 0;
            if (pos < cyc_low) cyc_low = pos;
            if (pos > cyc_high) cyc_high = pos;
            travel = cyc_high - cyc_low;
            case (phase)
                qsd_pkg::PH_DOWN: begin
                    if (cyc_low <= bottom_lvl) phase = qsd_pkg::PH_RETURN;
                    if (pos >= top_enter && cyc_low > bottom_lvl) begin
                        if (travel <= micro_lim) begin
                            n_micro++;
                            s_micro = s_micro + travel[47:0];
                        end else if (travel <= short_lim) begin
                            n_short++;
                            s_short = s_short + travel[47:0];
                        end
                        phase = qsd_pkg::PH_TOP;
                    end
                end
                qsd_pkg::PH_RETURN: begin
                    if (pos >= top_enter) begin
                        if (now - last_stroke >= gap_ms) begin
                            n_valid++;
                            last_stroke = now;
                            s_valid = s_valid + travel[47:0];
                            ring[slot] = now;
                            slot++;
                        end
                        phase = qsd_pkg::PH_TOP;
                    end
                end
                default: begin
                    phase = qsd_pkg::PH_TOP;
                    cyc_low = pos;
                    cyc_high = pos;
                    if (pos <= top_leave) phase = qsd_pkg::PH_DOWN;
                end
            endcase
        endfunction

        // Applies one accepted input beat and queues the result it must produce.
        function void note_beat(qsd_pkg::t_opcode op, bit a, bit b, bit [31:0] now);
            bit [1:0] pins;
            int d;
            bit [34:0] isum;
            bit [2:0] icnt;
            bit [31:0] t1, t2;
            pins = {a, b};
            case (op)
                qsd_pkg::OP_INIT: prev_pins = pins;
                qsd_pkg::OP_PINS: begin
                    d = step_tab[{prev_pins, pins}];
                    if (d != 0) begin
                        enc_pos = enc_pos + d;
                        moved = 1;
                    end
                    prev_pins = pins;
                end
                qsd_pkg::OP_TICK: tick(now);
                default: ;
            endcase
            isum = 0;
            icnt = 0;
            for (int i = 0; i < qsd_pkg::RATE_WINDOW; i++) begin
                t1 = ring[3'(slot - 1 - i)];
                t2 = ring[3'(slot - 2 - i)];
                if (t1 > 0 && t2 > 0 && t1 > t2) begin
                    isum = isum + (t1 - t2);
                    icnt++;
                end
            end
            pending_results.push_back({7'd0, icnt, isum, s_micro, s_short, s_valid,
                                       n_micro, n_short, n_valid, active, in_sess,
                                       2'(phase), enc_pos});
        endfunction

        // Compares one result beat, field by field, with the oldest expectation.
        function void check_beat(logic [351:0] got);
            bit [351:0] want;
            int lo;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending_results.pop_front();
            lo = 0;
            for (int f = 0; f < NFIELD; f++) begin
                if (((got >> lo) & ((352'd1 << FIELD_W[f]) - 1)) !==
                    ((want >> lo) & ((352'd1 << FIELD_W[f]) - 1))) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d: expected %h, got %h", f,
                                 (want >> lo) & ((352'd1 << FIELD_W[f]) - 1),
                                 (got >> lo) & ((352'd1 << FIELD_W[f]) - 1));
                end
                lo += FIELD_W[f];
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;  // [0] pin_a, [1] pin_b, [33:2] now_ms
    logic [1:0]   s_axis_tuser = '0;  // [1:0] opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [351:0] m_axis_tdata;       // position, phase, session_on, active_ms, counts, sums, intervals
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    stroke_scoreboard sb = new();
    int burst_left = 0;
    int rx_left = 0;
    bit rx_ready = 0;
    bit [1:0] pin_state = 0;
    bit [31:0] now_ms = 1;

    quadrature_stroke_detector_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // Receiver stalls on its own pattern: runs of ready and not ready.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_ready = ~rx_ready;
            rx_left = rx_ready ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        rx_left--;
        m_axis_tready <= rx_ready;
    end

    // Result monitor.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);

    // Sends one input beat, in bursts with random gaps in between.
    task automatic send_beat(qsd_pkg::t_opcode op, bit a, bit b, bit [31:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, now, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(op, a, b, now);
        @(negedge i_clk);
    endtask

    // Holds the sender until every expected result has been seen.
    task automatic drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        @(negedge i_clk);
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic write_all(bit [31:0] v0, bit [31:0] v1, bit [31:0] v2, bit [31:0] v3,
                             bit [31:0] v4, bit [31:0] v5, bit [31:0] v6, bit [31:0] v7);
        drain();
        write_reg(qsd_pkg::REG_TOP_LEAVE, v0);
        write_reg(qsd_pkg::REG_TOP_ENTER, v1);
        write_reg(qsd_pkg::REG_BOTTOM, v2);
        write_reg(qsd_pkg::REG_MICRO, v3);
        write_reg(qsd_pkg::REG_SHORT, v4);
        write_reg(qsd_pkg::REG_GAP, v5);
        write_reg(qsd_pkg::REG_IDLE, v6);
        write_reg(qsd_pkg::REG_TIMEOUT, v7);
    endtask

    // One encoder step in the given direction, following the Gray sequence.
    task automatic move(bit up);
        case (pin_state)
            2'b00: pin_state = up ? 2'b10 : 2'b01;
            2'b10: pin_state = up ? 2'b11 : 2'b00;
            2'b11: pin_state = up ? 2'b01 : 2'b10;
            default: pin_state = up ? 2'b00 : 2'b11;
        endcase
        send_beat(qsd_pkg::OP_PINS, pin_state[1], pin_state[0], 32'd0);
        if ($urandom_range(0, 2) == 0) begin
            now_ms += $urandom_range(1, 20);
            send_beat(qsd_pkg::OP_TICK, 0, 0, now_ms);
        end
    endtask

    // Random noise: bad pin pairs, init beats, unused opcode, odd tick times.
    task automatic noise();
        bit [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: send_beat(qsd_pkg::OP_PINS, r[0], r[1], r);
            1: begin
                send_beat(qsd_pkg::OP_INIT, r[0], r[1], r);
                pin_state = {r[0], r[1]};
            end
            2: send_beat(qsd_pkg::OP_NONE, r[0], r[1], r);
            3: send_beat(qsd_pkg::OP_TICK, r[0], r[1], r);
            default: begin
                now_ms += $urandom_range(500, 3000);
                send_beat(qsd_pkg::OP_TICK, r[0], r[1], now_ms);
            end
        endcase
    endtask

    // A stroke: down by a random depth, then back up past the top.
    task automatic stroke(int depth_max);
        int depth;
        longint target;
        depth = $urandom_range(0, depth_max);
        for (int i = 0; i < depth; i++) move(0);
        target = $urandom_range(0, 4);
        while (sb.position() < target) move(1);
        repeat ($urandom_range(1, 3)) begin
            now_ms += $urandom_range(1, 40);
            send_beat(qsd_pkg::OP_TICK, 0, 0, now_ms);
        end
        if ($urandom_range(0, 5) == 0) noise();
    endtask

    task automatic run_strokes(int beats, int depth_max);
        for (int k = 0; k < beats / 40; k++) stroke(depth_max);
    endtask

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: all-zero thresholds, ticks at time zero and at the top of time.
        send_beat(qsd_pkg::OP_INIT, 0, 0, 32'd0);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 1, 0, 32'd0);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 1, 1, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 0, 0, 32'd0);
        send_beat(qsd_pkg::OP_NONE, 1, 1, 32'hFFFF_FFFF);
        send_beat(qsd_pkg::OP_PINS, 0, 1, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 1, 0, 32'd0);
        send_beat(qsd_pkg::OP_TICK, 1, 1, 32'hFFFF_FFFF);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd5);
        send_beat(qsd_pkg::OP_INIT, 1, 1, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 0, 1, 32'd0);
        send_beat(qsd_pkg::OP_PINS, 0, 0, 32'd0);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd7);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd9);
        send_beat(qsd_pkg::OP_PINS, 0, 1, 32'd0);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'd12);
        send_beat(qsd_pkg::OP_TICK, 0, 0, 32'hAAAA_5555);
        pin_state = 2'b01;

        // Typical thresholds.
        write_all(-32'sd3, 32'd0, -32'sd20, 32'd4, 32'd12, 32'd30, 32'd200, 32'd1000);
        run_strokes(700, 40);
        drain();
        run_strokes(300, 40);

        // Extremes: thresholds at their far ends, time near wrap.
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        now_ms = 32'hFFFF_FF00;
        run_strokes(200, 20);

        // Opposite extremes: each tick moves the phase on, top to down to return and back to top.
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                  32'd0, 32'd0, 32'd0, 32'd0);
        run_strokes(200, 20);

        // Shallow strokes with short and micro classes, fast timeouts.
        write_all(-32'sd2, 32'd1, -32'sd25, 32'd3, 32'h7FFF_FFF0, 32'd5, 32'd15, 32'd40);
        now_ms = 32'd100;
        run_strokes(600, 30);

        drain();
        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
